// ===== sv/ate_pkg.sv =====
// Shared types, codes and constants of the ANSI text console engine.
package ate_pkg;

    localparam int DEF_ROWS = 64;
    localparam int DEF_COLS = 80;

    localparam logic [15:0] WHITE       = 16'hFFFF;
    localparam logic [15:0] COLOR_RED   = 16'hFAAA;
    localparam logic [15:0] COLOR_YEL   = 16'hFEAB;
    localparam logic [15:0] COLOR_BLUE  = 16'h5CBF;
    localparam logic [15:0] COLOR_CYAN  = 16'h66FF;
    localparam logic [15:0] RST_PRIMARY = 16'h07E0;
    localparam logic [15:0] RST_SECOND  = 16'hF81F;

    localparam logic [7:0] ESC_BYTE = 8'h1B;
    localparam logic [7:0] DEL_BYTE = 8'h7F;
    localparam logic [7:0] SPACE    = 8'h20;

    localparam logic [1:0] KIND_PUT   = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    localparam logic [9:0] SEL_RESET  = 10'd0;
    localparam logic [9:0] SEL_RED    = 10'd31;
    localparam logic [9:0] SEL_PRIM   = 10'd32;
    localparam logic [9:0] SEL_YEL    = 10'd33;
    localparam logic [9:0] SEL_BLUE   = 10'd34;
    localparam logic [9:0] SEL_SECOND = 10'd35;
    localparam logic [9:0] SEL_CYAN   = 10'd36;
    localparam logic [9:0] SEL_WHITE  = 10'd37;

    localparam logic [0:0] REG_PRIMARY = 1'b0;
    localparam logic [0:0] REG_SECOND  = 1'b1;

    typedef enum logic [3:0] {
        BC_ESC, BC_LBRACK, BC_DIGIT, BC_M, BC_NL, BC_CR, BC_TAB, BC_BS,
        BC_PRINT, BC_OTHER
    } byte_class_t;

    typedef enum logic [1:0] {
        PH_TEXT, PH_ESC, PH_CSI
    } esc_phase_t;

    typedef enum logic [2:0] {
        BK_IDLE, BK_EXEC, BK_SWEEP, BK_TAB, BK_PUT, BK_READ, BK_RESP
    } back_state_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  char_code;
        logic [15:0] default_color;
        logic [5:0]  read_row;
        logic [6:0]  read_col;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  cell_char;
        logic [15:0] cell_color;
        logic [5:0]  head_row;
        logic [6:0]  cursor_col;
        logic [15:0] current_color;
    } out_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        byte_class_t cls;
        logic [7:0]  ch;
        logic [15:0] dflt;
        logic [5:0]  read_row;
        logic [6:0]  read_col;
    } q_item_t;

endpackage

// ===== sv/ate_ram.sv =====
// Generic single write port RAM with registered read.
module ate_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ===== sv/ate_front.sv =====
// Front end: accepts transactions, classifies the byte and queues the work.
module ate_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  ate_pkg::in_item_t  s_data,
    input  logic               init_busy,
    output logic               q_valid,
    output ate_pkg::q_item_t   q_item,
    input  logic               q_pop
);
    import ate_pkg::*;

    function automatic byte_class_t classify(input logic [7:0] b);
        byte_class_t c;
        c = BC_OTHER;
        if (b == ESC_BYTE) c = BC_ESC;
        else if (b == 8'h5B) c = BC_LBRACK;
        else if (b >= 8'h30 && b <= 8'h39) c = BC_DIGIT;
        else if (b == 8'h6D) c = BC_M;
        else if (b == 8'h0A) c = BC_NL;
        else if (b == 8'h0D) c = BC_CR;
        else if (b == 8'h09) c = BC_TAB;
        else if (b == 8'h08 || b == DEL_BYTE) c = BC_BS;
        else if (b >= SPACE) c = BC_PRINT;
        return c;
    endfunction

    q_item_t    slot_reg [2];
    logic       wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;
    q_item_t    item;

    assign s_ready = (cnt_reg != 2'd2) && !init_busy;
    assign push    = s_valid && s_ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_item  = slot_reg[rp_reg];

    always_comb begin
        item.kind     = s_data.kind;
        item.cls      = classify(s_data.char_code);
        item.ch       = s_data.char_code;
        item.dflt     = s_data.default_color;
        item.read_row = s_data.read_row;
        item.read_col = s_data.read_col;
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = q_pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
        if (push) begin
            slot_reg[wp_reg] <= item;
        end
    end
endmodule

// ===== sv/ate_back.sv =====
// Back end: escape parser, cursor and row control, cell writes and result register.
module ate_back #(
    parameter int ROWS = ate_pkg::DEF_ROWS,
    parameter int COLS = ate_pkg::DEF_COLS
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_valid,
    input  ate_pkg::q_item_t   q_item,
    output logic               q_pop,
    output logic               init_busy,
    input  logic [15:0]        primary_accent,
    input  logic [15:0]        secondary_accent,
    output logic               m_valid,
    input  logic               m_ready,
    output ate_pkg::out_item_t m_data
);
    import ate_pkg::*;

    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLS + 1);
    localparam int CELLS = ROWS * COLS;
    localparam int AW    = $clog2(CELLS);

    back_state_t     state_reg, state_next;
    q_item_t         item_reg, item_next;
    logic [RW-1:0]   head_reg, head_next;
    logic [CW-1:0]   cur_reg, cur_next;
    logic [15:0]     color_reg, color_next;
    esc_phase_t      phase_reg, phase_next;
    logic [9:0]      num_reg, num_next;
    logic [ROWS-1:0] rv_reg, rv_next;
    logic [15:0]     wcol_reg, wcol_next;
    logic [15:0]     fill_reg, fill_next;
    logic [CW-1:0]   scol_reg, scol_next;
    logic            pend_reg, pend_next;
    logic            init_reg, init_next;
    logic            mv_reg, mv_next;
    out_item_t       mo_reg, mo_next;

    logic          ch_we, co_we;
    logic [CW-1:0] wcol_idx;
    logic [7:0]    ch_wd;
    logic [15:0]   co_wd;
    logic [AW-1:0] waddr, raddr;
    logic [7:0]    ch_rd;
    logic [15:0]   co_rd;

    logic [13:0]   prod;
    logic [9:0]    num_sat;
    logic [CW-1:0] cur_inc;
    logic [RW-1:0] head_inc;
    logic          in_range;
    logic [RW-1:0] rr_idx;
    logic          text;
    logic [15:0]   tcol;

    assign waddr = AW'(32'(head_reg) * COLS + 32'(wcol_idx));
    assign raddr = AW'(32'(item_reg.read_row) * COLS + 32'(item_reg.read_col));

    ate_ram #(.WIDTH(8), .DEPTH(CELLS)) u_char_ram (
        .aclk(aclk), .we(ch_we), .waddr(waddr), .wdata(ch_wd),
        .raddr(raddr), .rdata(ch_rd)
    );

    ate_ram #(.WIDTH(16), .DEPTH(CELLS)) u_color_ram (
        .aclk(aclk), .we(co_we), .waddr(waddr), .wdata(co_wd),
        .raddr(raddr), .rdata(co_rd)
    );

    assign init_busy = init_reg;
    assign m_valid   = mv_reg;
    assign m_data    = mo_reg;

    always_comb begin
        prod     = 14'(num_reg) * 14'd10 + 14'(item_reg.ch[3:0]);
        num_sat  = (prod > 14'd1023) ? 10'd1023 : prod[9:0];
        cur_inc  = cur_reg + CW'(1);
        head_inc = (head_reg == RW'(ROWS - 1)) ? RW'(0) : head_reg + RW'(1);
        in_range = (32'(item_reg.read_row) < ROWS) && (32'(item_reg.read_col) < COLS);
        rr_idx   = RW'(item_reg.read_row);
        tcol     = (color_reg != WHITE) ? color_reg : item_reg.dflt;

        state_next = state_reg;
        item_next  = item_reg;
        head_next  = head_reg;
        cur_next   = cur_reg;
        color_next = color_reg;
        phase_next = phase_reg;
        num_next   = num_reg;
        rv_next    = rv_reg;
        wcol_next  = wcol_reg;
        fill_next  = fill_reg;
        scol_next  = scol_reg;
        pend_next  = pend_reg;
        init_next  = init_reg;
        mv_next    = mv_reg && !m_ready;
        mo_next    = mo_reg;
        q_pop      = 1'b0;
        ch_we      = 1'b0;
        co_we      = 1'b0;
        wcol_idx   = cur_reg;
        ch_wd      = 8'd0;
        co_wd      = fill_reg;
        text       = 1'b0;

        unique case (state_reg)
            BK_IDLE: begin
                if (q_valid) begin
                    q_pop      = 1'b1;
                    item_next  = q_item;
                    state_next = BK_EXEC;
                end
            end
            BK_EXEC: begin
                state_next = BK_READ;
                if (item_reg.kind == KIND_CLEAR) begin
                    head_next  = '0;
                    cur_next   = '0;
                    color_next = WHITE;
                    phase_next = PH_TEXT;
                    rv_next    = '0;
                    fill_next  = WHITE;
                    scol_next  = '0;
                    pend_next  = 1'b0;
                    state_next = BK_SWEEP;
                end else if (item_reg.kind == KIND_PUT) begin
                    unique case (phase_reg)
                        PH_ESC: begin
                            phase_next = PH_TEXT;
                            if (item_reg.cls == BC_LBRACK) begin
                                phase_next = PH_CSI;
                                num_next   = '0;
                            end else begin
                                text = 1'b1;
                            end
                        end
                        PH_CSI: begin
                            if (item_reg.cls == BC_DIGIT) begin
                                num_next = num_sat;
                            end else begin
                                phase_next = PH_TEXT;
                                if (item_reg.cls == BC_M) begin
                                    unique case (num_reg)
                                        SEL_RESET, SEL_WHITE: color_next = WHITE;
                                        SEL_RED:    color_next = COLOR_RED;
                                        SEL_PRIM:   color_next = primary_accent;
                                        SEL_YEL:    color_next = COLOR_YEL;
                                        SEL_BLUE:   color_next = COLOR_BLUE;
                                        SEL_SECOND: color_next = secondary_accent;
                                        SEL_CYAN:   color_next = COLOR_CYAN;
                                        default:    color_next = color_reg;
                                    endcase
                                end
                            end
                        end
                        default: begin
                            if (item_reg.cls == BC_ESC) begin
                                phase_next = PH_ESC;
                            end else begin
                                text = 1'b1;
                            end
                        end
                    endcase
                    if (text) begin
                        wcol_next = tcol;
                        unique case (item_reg.cls)
                            BC_NL: begin
                                head_next  = head_inc;
                                cur_next   = '0;
                                fill_next  = color_reg;
                                scol_next  = '0;
                                pend_next  = 1'b0;
                                state_next = BK_SWEEP;
                            end
                            BC_CR: cur_next = '0;
                            BC_TAB: begin
                                if (cur_reg >= CW'(COLS)) begin
                                    head_next  = head_inc;
                                    cur_next   = '0;
                                    fill_next  = color_reg;
                                    scol_next  = '0;
                                    pend_next  = 1'b0;
                                    state_next = BK_SWEEP;
                                end else begin
                                    state_next = BK_TAB;
                                end
                            end
                            BC_BS: begin
                                if (cur_reg != '0) begin
                                    cur_next = cur_reg - CW'(1);
                                    wcol_idx = cur_reg - CW'(1);
                                    ch_we    = 1'b1;
                                end
                            end
                            BC_PRINT, BC_LBRACK, BC_DIGIT, BC_M: begin
                                if (cur_reg >= CW'(COLS)) begin
                                    head_next  = head_inc;
                                    cur_next   = '0;
                                    fill_next  = color_reg;
                                    scol_next  = '0;
                                    pend_next  = 1'b1;
                                    state_next = BK_SWEEP;
                                end else begin
                                    state_next = BK_PUT;
                                end
                            end
                            default: state_next = BK_READ;
                        endcase
                    end
                end
            end
            BK_SWEEP: begin
                wcol_idx  = scol_reg;
                ch_we     = 1'b1;
                co_we     = 1'b1;
                scol_next = scol_reg + CW'(1);
                if (scol_reg == CW'(COLS - 1)) begin
                    rv_next[head_reg] = 1'b1;
                    init_next         = 1'b0;
                    state_next        = init_reg ? BK_IDLE : (pend_reg ? BK_PUT : BK_READ);
                end
            end
            BK_TAB: begin
                ch_we    = 1'b1;
                co_we    = 1'b1;
                ch_wd    = SPACE;
                co_wd    = wcol_reg;
                cur_next = cur_inc;
                if (cur_inc >= CW'(COLS)) begin
                    head_next  = head_inc;
                    cur_next   = '0;
                    fill_next  = color_reg;
                    scol_next  = '0;
                    pend_next  = 1'b0;
                    state_next = BK_SWEEP;
                end else if (cur_inc[2:0] == 3'd0) begin
                    state_next = BK_READ;
                end
            end
            BK_PUT: begin
                ch_we      = 1'b1;
                co_we      = 1'b1;
                ch_wd      = item_reg.ch;
                co_wd      = wcol_reg;
                cur_next   = cur_inc;
                state_next = BK_READ;
            end
            BK_READ: state_next = BK_RESP;
            BK_RESP: begin
                if (!mv_reg || m_ready) begin
                    mv_next = 1'b1;
                    if (!in_range) begin
                        mo_next.cell_char  = 8'd0;
                        mo_next.cell_color = 16'd0;
                    end else if (!rv_reg[rr_idx]) begin
                        mo_next.cell_char  = 8'd0;
                        mo_next.cell_color = WHITE;
                    end else begin
                        mo_next.cell_char  = ch_rd;
                        mo_next.cell_color = co_rd;
                    end
                    mo_next.head_row      = 6'((RW + 6)'(head_reg));
                    mo_next.cursor_col    = 7'((CW + 7)'(cur_reg));
                    mo_next.current_color = color_reg;
                    state_next            = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BK_SWEEP;
            head_reg  <= '0;
            cur_reg   <= '0;
            color_reg <= WHITE;
            phase_reg <= PH_TEXT;
            num_reg   <= '0;
            rv_reg    <= '0;
            fill_reg  <= WHITE;
            scol_reg  <= '0;
            pend_reg  <= 1'b0;
            init_reg  <= 1'b1;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            cur_reg   <= cur_next;
            color_reg <= color_next;
            phase_reg <= phase_next;
            num_reg   <= num_next;
            rv_reg    <= rv_next;
            fill_reg  <= fill_next;
            scol_reg  <= scol_next;
            pend_reg  <= pend_next;
            init_reg  <= init_next;
            mv_reg    <= mv_next;
        end
        item_reg <= item_next;
        wcol_reg <= wcol_next;
        mo_reg   <= mo_next;
    end
endmodule

// ===== sv/ansi_text_console_engine.sv =====
// Each transaction leaves the queue and passes BK_EXEC, BK_READ and BK_RESP; a printable byte adds a BK_PUT cell write.
// Printable byte on a full row, newline, or a tab that fills the row: the new row is also cleared.
// Tab: its spaces are written one cell at a time. Clear screen: row 0 is swept.
// The back end finishes one transaction before it takes the next; a two-deep queue decouples input.
// Reset: synchronous, active low; afterwards row 0 is swept while s_ready is held low.
// Other rows read blank until first cleared, tracked by one valid bit per row.
module ansi_text_console_engine #(
    parameter int ROWS = ate_pkg::DEF_ROWS,
    parameter int COLS = ate_pkg::DEF_COLS
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  ate_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output ate_pkg::out_item_t m_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import ate_pkg::*;

    logic [15:0] primary_reg, second_reg;
    logic        q_valid, q_pop, init_busy;
    q_item_t     q_item;

    assign pready = 1'b1;

    always_comb begin
        unique case (paddr[2])
            REG_PRIMARY: prdata = {16'd0, primary_reg};
            default:     prdata = {16'd0, second_reg};
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            primary_reg <= RST_PRIMARY;
            second_reg  <= RST_SECOND;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == REG_PRIMARY) begin
                primary_reg <= pwdata[15:0];
            end else begin
                second_reg <= pwdata[15:0];
            end
        end
    end

    ate_front u_front (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .s_data(s_data), .init_busy(init_busy), .q_valid(q_valid),
        .q_item(q_item), .q_pop(q_pop)
    );

    ate_back #(.ROWS(ROWS), .COLS(COLS)) u_back (
        .aclk(aclk), .aresetn(aresetn), .q_valid(q_valid), .q_item(q_item),
        .q_pop(q_pop), .init_busy(init_busy), .primary_accent(primary_reg),
        .secondary_accent(second_reg), .m_valid(m_valid), .m_ready(m_ready),
        .m_data(m_data)
    );
endmodule

// ===== sv/ate_checker.sv =====
// Port-level checker for the console engine, bound to the top level.
module ate_checker #(
    parameter int ROWS = ate_pkg::DEF_ROWS,
    parameter int COLS = ate_pkg::DEF_COLS
) (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input ate_pkg::out_item_t m_data,
    input logic               pready
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_rst: assert property (@(posedge aclk) !aresetn |=> !m_valid && !s_ready)
        else $error("busy right after reset");

    a_cur: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> 32'(m_data.cursor_col) <= COLS)
        else $error("cursor beyond row");

    a_head: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && ROWS <= 64 |-> 32'(m_data.head_row) < ROWS)
        else $error("head row out of ring");

    a_pready: assert property (@(posedge aclk) pready)
        else $error("pready low");
endmodule

bind ansi_text_console_engine ate_checker #(.ROWS(ROWS), .COLS(COLS)) u_ate_checker (
    .aclk(aclk), .aresetn(aresetn), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data), .pready(pready)
);

// ===== tb/sv/ansi_text_console_engine_test.sv =====
// Self-checking testbench for the ANSI text console engine: random and directed transactions.
`timescale 1ns / 1ps
module ansi_text_console_engine_test;
    import ate_pkg::*;

    localparam int ROWS = DEF_ROWS;
    localparam int COLS = DEF_COLS;
    localparam int NCELL = ROWS * COLS;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    in_item_t    s_data;
    logic        m_valid;
    logic        m_ready;
    out_item_t   m_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    ansi_text_console_engine u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    logic [7:0]  scr_char [NCELL];
    logic [15:0] scr_color [NCELL];
    int          scr_head;
    int          scr_cursor;
    logic [15:0] scr_active;
    int          scr_phase;
    int          scr_number;
    logic [15:0] acc_primary;
    logic [15:0] acc_second;

    in_item_t  pending_items[$];
    out_item_t expected_cells[$];
    int        mismatch_count;
    bit        hold_sink;
    bit        hold_source;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #20ms;
        $display("tb: failure");
        $finish;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void screen_wipe();
        scr_head = 0;
        scr_cursor = 0;
        scr_active = WHITE;
        scr_phase = 0;
        for (int i = 0; i < NCELL; i++) begin
            scr_char[i] = 8'h00;
            scr_color[i] = WHITE;
        end
    endfunction

    function automatic void row_advance();
        scr_head = (scr_head + 1) % ROWS;
        scr_cursor = 0;
        for (int c = 0; c < COLS; c++) begin
            scr_char[scr_head * COLS + c] = 8'h00;
            scr_color[scr_head * COLS + c] = scr_active;
        end
    endfunction

    function automatic void color_select();
        case (scr_number)
            SEL_RESET, SEL_WHITE: scr_active = WHITE;
            SEL_RED:    scr_active = COLOR_RED;
            SEL_PRIM:   scr_active = acc_primary;
            SEL_YEL:    scr_active = COLOR_YEL;
            SEL_BLUE:   scr_active = COLOR_BLUE;
            SEL_SECOND: scr_active = acc_second;
            SEL_CYAN:   scr_active = COLOR_CYAN;
            default: ;
        endcase
    endfunction

    function automatic void byte_put(logic [7:0] ch, logic [15:0] dflt);
        logic [15:0] col;
        int stop;
        if (scr_phase == 1) begin
            scr_phase = 0;
            if (ch == "[") begin
                scr_phase = 2;
                scr_number = 0;
                return;
            end
        end else if (scr_phase == 2) begin
            if (ch >= "0" && ch <= "9") begin
                scr_number = scr_number * 10 + (ch - "0");
                if (scr_number > 1023) scr_number = 1023;
                return;
            end
            if (ch == "m") color_select();
            scr_phase = 0;
            return;
        end else if (ch == ESC_BYTE) begin
            scr_phase = 1;
            return;
        end
        col = (scr_active != WHITE) ? scr_active : dflt;
        if (ch == 8'h0A) begin
            row_advance();
        end else if (ch == 8'h0D) begin
            scr_cursor = 0;
        end else if (ch == 8'h09) begin
            stop = (scr_cursor + 8) & ~7;
            while (scr_cursor < stop && scr_cursor < COLS) begin
                scr_char[scr_head * COLS + scr_cursor] = SPACE;
                scr_color[scr_head * COLS + scr_cursor] = col;
                scr_cursor++;
            end
            if (scr_cursor >= COLS) row_advance();
        end else if (ch == 8'h08 || ch == DEL_BYTE) begin
            if (scr_cursor > 0) begin
                scr_cursor--;
                scr_char[scr_head * COLS + scr_cursor] = 8'h00;
            end
        end else if (ch >= 8'h20) begin
            if (scr_cursor >= COLS) row_advance();
            scr_char[scr_head * COLS + scr_cursor] = ch;
            scr_color[scr_head * COLS + scr_cursor] = col;
            scr_cursor++;
        end
    endfunction

    function automatic out_item_t console_step(in_item_t it);
        out_item_t r;
        if (it.kind == KIND_PUT) byte_put(it.char_code, it.default_color);
        else if (it.kind == KIND_CLEAR) screen_wipe();
        if (it.read_row < ROWS && it.read_col < COLS) begin
            r.cell_char = scr_char[it.read_row * COLS + it.read_col];
            r.cell_color = scr_color[it.read_row * COLS + it.read_col];
        end else begin
            r.cell_char = 8'h00;
            r.cell_color = 16'h0000;
        end
        r.head_row = scr_head[5:0];
        r.cursor_col = scr_cursor[6:0];
        r.current_color = scr_active;
        return r;
    endfunction

    int src_gap;
    bit s_taken;
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_data <= '0;
            src_gap <= 0;
        end else if (s_valid && !s_taken) begin
        end else if (src_gap > 0) begin
            s_valid <= 1'b0;
            src_gap <= src_gap - 1;
        end else if (!hold_source && pending_items.size() > 0) begin
            s_valid <= 1'b1;
            s_data <= pending_items.pop_front();
            src_gap <= gap_len();
        end else begin
            s_valid <= 1'b0;
        end
    end

    always @(posedge aclk) begin
        s_taken <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready)
            expected_cells.push_back(console_step(s_data));
    end

    int sink_gap;
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            sink_gap <= 0;
        end else if (hold_sink) begin
            m_ready <= 1'b0;
        end else if (sink_gap > 0) begin
            m_ready <= 1'b0;
            sink_gap <= sink_gap - 1;
        end else begin
            m_ready <= 1'b1;
            sink_gap <= ($urandom_range(0, 2) == 0) ? gap_len() : 0;
        end
    end

    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_cells.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected transaction %h", m_data);
            end else begin
                want = expected_cells.pop_front();
                if (m_data.cell_char !== want.cell_char
                        || m_data.cell_color !== want.cell_color
                        || m_data.head_row !== want.head_row
                        || m_data.cursor_col !== want.cursor_col
                        || m_data.current_color !== want.current_color) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected %h actual %h", want, m_data);
                end
            end
        end
    end

    task automatic reg_write(logic [0:0] idx, logic [15:0] val);
        @(negedge aclk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {16'h0, val};
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_PRIMARY) acc_primary = val;
        else acc_second = val;
    endtask

    task automatic drain();
        while (pending_items.size() > 0 || s_valid || expected_cells.size() > 0)
            @(posedge aclk);
        repeat (2 * COLS + 20) @(posedge aclk);
    endtask

    function automatic in_item_t make_put(logic [7:0] ch);
        in_item_t it;
        it.kind = KIND_PUT;
        it.char_code = ch;
        it.default_color = 16'($urandom);
        it.read_row = 6'($urandom_range(0, 3));
        it.read_col = 7'($urandom_range(0, COLS - 1));
        return it;
    endfunction

    // Rows other than 0 read blank until cleared; in-range reads stay at or below rows_seen.
    int rows_seen;

    function automatic in_item_t random_item();
        in_item_t it;
        int r;
        it = make_put(8'($urandom));
        r = $urandom_range(0, 99);
        if (r < 40) it.char_code = 8'($urandom_range(32, 126));
        else if (r < 48) it.char_code = 8'h0A;
        else if (r < 52) it.char_code = 8'h09;
        else if (r < 56) it.char_code = 8'h08;
        else if (r < 58) it.char_code = DEL_BYTE;
        else if (r < 60) it.char_code = 8'h0D;
        else if (r < 63) it.kind = KIND_READ;
        else if (r < 64) it.kind = KIND_CLEAR;
        else if (r < 65) it.kind = 2'd3;
        if ($urandom_range(0, 9) == 0) begin
            it.read_row = 6'($urandom);
            it.read_col = 7'($urandom_range(COLS, 127));
        end else begin
            it.read_row = 6'($urandom_range(0, rows_seen));
        end
        return it;
    endfunction

    task automatic push_tracked(in_item_t it);
        if (it.kind == KIND_CLEAR) rows_seen = 0;
        if (it.kind == KIND_PUT && (it.char_code == 8'h0A || it.char_code >= 8'h20
                || it.char_code == 8'h09))
            rows_seen = (rows_seen + 1 < ROWS) ? rows_seen + 1 : ROWS - 1;
        if (it.read_col < COLS && it.read_row > rows_seen) it.read_row = 6'(rows_seen);
        pending_items.push_back(it);
    endtask

    task automatic push_escape(int num, bit broken);
        string s;
        s = $sformatf("%0d", num);
        push_tracked(make_put(ESC_BYTE));
        push_tracked(make_put(broken ? 8'h41 : "["));
        for (int i = 0; i < s.len(); i++) push_tracked(make_put(s[i]));
        push_tracked(make_put(broken ? 8'h3B : "m"));
    endtask

    initial begin
        int sel[] = '{0, 31, 32, 33, 34, 35, 36, 37, 99, 5000};
        in_item_t it;
        aresetn = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        hold_sink = 1'b0;
        hold_source = 1'b0;
        mismatch_count = 0;
        rows_seen = 0;
        acc_primary = RST_PRIMARY;
        acc_second = RST_SECOND;
        screen_wipe();
        scr_number = 0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (sel[i]) begin
            push_escape(sel[i], 1'b0);
            push_tracked(make_put("A"));
        end
        it = make_put(8'hFF);
        it.default_color = 16'hFFFF;
        push_tracked(it);
        it = make_put(8'h00);
        it.default_color = 16'h0000;
        push_tracked(it);
        it.kind = KIND_READ;
        it.read_row = 6'h3F;
        it.read_col = 7'h7F;
        push_tracked(it);
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin reg_write(REG_PRIMARY, 16'h0000); reg_write(REG_SECOND, 16'hFFFF); end
                1: begin reg_write(REG_PRIMARY, 16'hFFFF); reg_write(REG_SECOND, 16'h0000); end
                default: begin
                    reg_write(REG_PRIMARY, 16'($urandom));
                    reg_write(REG_SECOND, 16'($urandom));
                end
            endcase
            for (int n = 0; n < 100; n++) begin
                if ($urandom_range(0, 9) == 0)
                    push_escape($urandom_range(0, 3) == 0 ? $urandom_range(0, 1500)
                                : sel[$urandom_range(0, 7)], $urandom_range(0, 5) == 0);
                else
                    push_tracked(random_item());
            end
            if (phase == 1) begin
                hold_sink = 1'b1;
                repeat (400) @(posedge aclk);
                hold_sink = 1'b0;
            end
            if (phase == 2) begin
                while (pending_items.size() > 75) @(posedge aclk);
                hold_source = 1'b1;
                while (expected_cells.size() > 0 || s_valid) @(posedge aclk);
                hold_source = 1'b0;
            end
            drain();
        end

        if (mismatch_count == 0 && expected_cells.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
